/* src/clrc_pkg.sv */
`default_nettype none

package clrc_pkg;

  localparam int SCHED_DEPTH_DEF = 16;
  localparam int MS_PER_SECOND   = 1000;
  localparam int HUM_BAND_TENTHS = 30;
  localparam int DAYS_MAX        = 65535;

  localparam logic signed [11:0] DEF_MIN_TENTHS = 12'sd280;
  localparam logic signed [11:0] DEF_MAX_TENTHS = 12'sd320;

  localparam logic [2:0] MODE_AUTO  = 3'd0;
  localparam logic [2:0] MODE_OFF   = 3'd1;
  localparam logic [2:0] MODE_ON    = 3'd2;
  localparam logic [2:0] MODE_HALF  = 3'd3;
  localparam logic [2:0] MODE_SCHED = 3'd4;
  localparam logic [2:0] MODE_COUNT = 3'd5;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_AUTO_MIN   = 3'd1;
  localparam logic [2:0] REG_AUTO_MAX   = 3'd2;
  localparam logic [2:0] REG_DELAY      = 3'd3;
  localparam logic [2:0] REG_HUM_LIMIT  = 3'd4;
  localparam logic [2:0] REG_GAS_LIMIT  = 3'd5;
  localparam logic [2:0] REG_START_DAY  = 3'd6;
  localparam logic [2:0] REG_SCHED_CNT  = 3'd7;

  typedef enum logic [1:0] {
    ZONE_COLD   = 2'd0,
    ZONE_INSIDE = 2'd1,
    ZONE_HOT    = 2'd2,
    ZONE_NONE   = 2'd3
  } zone_t;

  typedef struct packed {
    logic [15:0]        offset;
    logic signed [11:0] min_t;
    logic signed [11:0] max_t;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic signed [11:0] lo;
    logic signed [11:0] hi;
  } thr_t;

  function automatic logic [2:0] mode_norm(input logic [2:0] m);
    mode_norm = (m >= MODE_COUNT) ? (m - MODE_COUNT) : m;
  endfunction

  function automatic zone_t classify(input logic signed [11:0] t,
                                     input logic signed [11:0] lo,
                                     input logic signed [11:0] hi);
    if (t <= lo) begin
      classify = ZONE_COLD;
    end else if (t < hi) begin
      classify = ZONE_INSIDE;
    end else begin
      classify = ZONE_HOT;
    end
  endfunction

  // Returns {heater one level, heater two level}; a low level turns a heater on.
  function automatic logic [1:0] heater_levels(input zone_t z);
    case (z)
      ZONE_COLD:   heater_levels = 2'b00;
      ZONE_INSIDE: heater_levels = 2'b10;
      default:     heater_levels = 2'b11;
    endcase
  endfunction

endpackage

`default_nettype wire

/* src/clrc_ram.sv */
`default_nettype none

module clrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/clrc_walk.sv */
`default_nettype none

module clrc_walk import clrc_pkg::*; #(
  parameter int DEPTH = SCHED_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [15:0]   days,
  input  wire logic [CW-1:0] count,
  output logic      [AW-1:0] raddr,
  input  wire entry_t        rdata,
  output logic               done,
  output thr_t               thr
);

  logic          busy_r;
  logic          pend_r;
  logic          done_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   days_r;
  thr_t          thr_r;
  logic          stop;
  logic          more;

  // One entry is issued and the previous one checked in every cycle.
  assign stop  = pend_r && (rdata.offset > days_r);
  assign more  = idx_r < cnt_r;
  assign raddr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pend_r <= 1'b0;
      end else if (busy_r) begin
        if (stop || !more) begin
          busy_r <= 1'b0;
          pend_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          pend_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r  <= '0;
      cnt_r  <= count;
      days_r <= days;
      thr_r  <= '{lo: DEF_MIN_TENTHS, hi: DEF_MAX_TENTHS};
    end else if (busy_r && !stop) begin
      if (pend_r) begin
        thr_r <= '{lo: rdata.min_t, hi: rdata.max_t};
      end
      if (more) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign thr  = thr_r;

endmodule

`default_nettype wire

/* src/climate_relay_controller_core.sv */
`default_nettype none

// Relay controller for a climate chamber. Each word on the input channel is
// either a control tick (op 0) carrying temperature, humidity, gas and time,
// or a schedule slot write (op 1). Every input word yields exactly one word
// on the output channel with the four relay pin levels (low means on) and
// the zone classified on that tick (none in forced modes and slot writes).
// A word is taken when the block is idle, so a new word is not taken before
// the previous one has left its done state. A tick in auto or a forced mode
// passes the classify, apply and done states before out_valid rises; a schedule
// tick first walks the schedule memory, one entry at a time through its single
// read port, so that walk grows with the number of entries walked. A slot write
// passes the write and done states.
// The output word sits in a register, so a new input word can be accepted
// while the previous result waits; a stalled receiver holds the finished
// result and, after that, holds the block before it loads the next one.
// Reset restores the register defaults, the pin state and the zone
// trackers. Schedule slots are not cleared and must be written before use.
// Configuration writes take effect at once and belong to idle periods.
module climate_relay_controller_core import clrc_pkg::*; #(
  parameter int SCHEDULE_DEPTH = SCHED_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic signed [11:0] in_temperature_tenths,
  input  wire logic [9:0]         in_humidity_tenths,
  input  wire logic [11:0]        in_gas_reading,
  input  wire logic [31:0]        in_time_ms,
  input  wire logic [16:0]        in_day_number,
  input  wire logic [3:0]         in_entry_index,
  input  wire logic [15:0]        in_entry_day_offset,
  input  wire logic signed [11:0] in_entry_min_tenths,
  input  wire logic signed [11:0] in_entry_max_tenths,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_heater_one_level,
  output logic                    out_heater_two_level,
  output logic                    out_vent_level,
  output logic                    out_mist_level,
  output logic [1:0]              out_zone_seen
);

  localparam int AW = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;
  localparam int CW = $clog2(SCHEDULE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_CLASS = 6'b000100,
    S_APPLY = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]         mode_r;
  logic signed [11:0] auto_min_r;
  logic signed [11:0] auto_max_r;
  logic [11:0]        delay_r;
  logic [9:0]         hum_lim_r;
  logic [11:0]        gas_lim_r;
  logic [16:0]        start_day_r;
  logic [4:0]         sched_cnt_r;

  logic               h1_r, h2_r, vent_r, mist_r;
  zone_t              a_pend_r, s_pend_r, s_applied_r;
  logic [31:0]        a_since_r, s_since_r;

  logic signed [11:0] temp_r;
  logic [9:0]         hum_r;
  logic [11:0]        gas_r;
  logic [31:0]        time_r;
  logic [3:0]         eidx_r;
  entry_t             ent_r;
  zone_t              zone_r;
  zone_t              seen_r;
  logic [31:0]        elapsed_r;

  logic               out_valid_r;
  logic               o_h1_r, o_h2_r, o_vent_r, o_mist_r;
  zone_t              o_zone_r;

  logic [2:0]         mode_n;
  logic               accept;
  logic               walk_start;
  logic [15:0]        days_c;
  logic signed [17:0] days_diff;
  logic [CW-1:0]      count_c;
  logic [AW-1:0]      raddr;
  entry_t             rdata;
  logic               walk_done;
  thr_t               walk_thr;
  thr_t               thr_c;
  zone_t              zone_c;
  zone_t              pend_c;
  logic [31:0]        since_c;
  logic [31:0]        elapsed_c;
  logic [31:0]        delay_ms;
  logic               held;
  logic               ram_we;
  logic [1:0]         lv;
  logic [10:0]        h_ext, lim_ext;
  logic               vent_h, mist_h, vent_c, mist_c;
  logic               out_free;

  assign mode_n     = mode_norm(mode_r);
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign walk_start = accept && !in_op && (mode_n == MODE_SCHED);
  assign out_free   = !out_valid_r || out_ready;

  // Days since the schedule began (16-bit clamp); slot count capped at depth.
  always_comb begin
    days_diff = $signed({1'b0, in_day_number}) - $signed({1'b0, start_day_r});
    if (start_day_r == '0 || days_diff < 0) begin
      days_c = '0;
    end else if (days_diff > DAYS_MAX) begin
      days_c = 16'(DAYS_MAX);
    end else begin
      days_c = days_diff[15:0];
    end
    if (32'(sched_cnt_r) > SCHEDULE_DEPTH) begin
      count_c = CW'(SCHEDULE_DEPTH);
    end else begin
      count_c = CW'(sched_cnt_r);
    end
  end

  assign ram_we = (state_r == S_WRITE) && (32'(eidx_r) < SCHEDULE_DEPTH);

  clrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SCHEDULE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(eidx_r)),
    .wdata (ent_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  clrc_walk #(
    .DEPTH (SCHEDULE_DEPTH)
  ) u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (walk_start),
    .days  (days_c),
    .count (count_c),
    .raddr (raddr),
    .rdata (rdata),
    .done  (walk_done),
    .thr   (walk_thr)
  );

  always_comb begin
    if (mode_n == MODE_SCHED) begin
      thr_c   = walk_thr;
      pend_c  = s_pend_r;
      since_c = s_since_r;
    end else begin
      thr_c   = '{lo: auto_min_r, hi: auto_max_r};
      pend_c  = a_pend_r;
      since_c = a_since_r;
    end
    zone_c    = classify(temp_r, thr_c.lo, thr_c.hi);
    elapsed_c = (zone_c != pend_c) ? '0 : (time_r - since_c);
    delay_ms  = 32'(delay_r) * 32'(MS_PER_SECOND);
    held      = elapsed_r >= delay_ms;
    lv        = heater_levels(zone_r);
    h_ext     = {1'b0, hum_r};
    lim_ext   = {1'b0, hum_lim_r};
    vent_h    = h_ext > (lim_ext + 11'(HUM_BAND_TENTHS));
    mist_h    = (h_ext + 11'(HUM_BAND_TENTHS)) < lim_ext;
    vent_c    = vent_h || (gas_r > gas_lim_r);
    mist_c    = !vent_h && mist_h;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op) begin
            state_nxt = S_WRITE;
          end else if (mode_n == MODE_SCHED) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_CLASS;
          end
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_DONE;
      S_WRITE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_AUTO;
      auto_min_r  <= DEF_MIN_TENTHS;
      auto_max_r  <= DEF_MAX_TENTHS;
      delay_r     <= 12'd10;
      hum_lim_r   <= 10'd700;
      gas_lim_r   <= 12'd2000;
      start_day_r <= '0;
      sched_cnt_r <= '0;
      h1_r        <= 1'b0;
      h2_r        <= 1'b0;
      vent_r      <= 1'b0;
      mist_r      <= 1'b0;
      a_pend_r    <= ZONE_NONE;
      s_pend_r    <= ZONE_NONE;
      s_applied_r <= ZONE_NONE;
      a_since_r   <= '0;
      s_since_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:      mode_r      <= cfg_data[2:0];
          REG_AUTO_MIN:  auto_min_r  <= $signed(cfg_data[11:0]);
          REG_AUTO_MAX:  auto_max_r  <= $signed(cfg_data[11:0]);
          REG_DELAY:     delay_r     <= cfg_data[11:0];
          REG_HUM_LIMIT: hum_lim_r   <= cfg_data[9:0];
          REG_GAS_LIMIT: gas_lim_r   <= cfg_data[11:0];
          REG_START_DAY: start_day_r <= cfg_data;
          REG_SCHED_CNT: sched_cnt_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state_r == S_CLASS) begin
        if (mode_n == MODE_AUTO && zone_c != a_pend_r) begin
          a_pend_r  <= zone_c;
          a_since_r <= time_r;
        end
        if (mode_n == MODE_SCHED && zone_c != s_pend_r) begin
          s_pend_r  <= zone_c;
          s_since_r <= time_r;
        end
      end
      if (state_r == S_APPLY) begin
        case (mode_n)
          MODE_AUTO: begin
            if (held) begin
              {h1_r, h2_r} <= lv;
            end
          end
          MODE_OFF:  {h1_r, h2_r} <= 2'b11;
          MODE_ON:   {h1_r, h2_r} <= 2'b00;
          MODE_HALF: {h1_r, h2_r} <= 2'b01;
          MODE_SCHED: begin
            if (held && s_applied_r != zone_r) begin
              s_applied_r  <= zone_r;
              {h1_r, h2_r} <= lv;
            end
          end
          default: ;
        endcase
        vent_r <= !vent_c;
        mist_r <= !mist_c;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      temp_r <= in_temperature_tenths;
      hum_r  <= in_humidity_tenths;
      gas_r  <= in_gas_reading;
      time_r <= in_time_ms;
      eidx_r <= in_entry_index;
      ent_r  <= '{offset: in_entry_day_offset, min_t: in_entry_min_tenths,
                  max_t: in_entry_max_tenths};
    end
    if (state_r == S_CLASS) begin
      zone_r    <= zone_c;
      elapsed_r <= elapsed_c;
      if (mode_n == MODE_AUTO || mode_n == MODE_SCHED) begin
        seen_r <= zone_c;
      end else begin
        seen_r <= ZONE_NONE;
      end
    end
    if (state_r == S_WRITE) begin
      seen_r <= ZONE_NONE;
    end
    if (state_r == S_DONE && out_free) begin
      o_h1_r   <= h1_r;
      o_h2_r   <= h2_r;
      o_vent_r <= vent_r;
      o_mist_r <= mist_r;
      o_zone_r <= seen_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_heater_one_level = o_h1_r;
  assign out_heater_two_level = o_h2_r;
  assign out_vent_level       = o_vent_r;
  assign out_mist_level       = o_mist_r;
  assign out_zone_seen        = o_zone_r;

  a_walk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |-> state_r == S_WALK)
    else $error("schedule walk finished outside the walk state");

  a_tick_to_class: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_op && mode_n != MODE_SCHED) |=> state_r == S_CLASS)
    else $error("non-schedule tick did not go straight to classification");

  a_write_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op) |=> state_r == S_WRITE && !walk_done)
    else $error("slot write did not go to the write state");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside the done state");

endmodule

`default_nettype wire

/* sim/climate_relay_controller_core_tb.sv */
module climate_relay_controller_core_tb;
  import clrc_pkg::*;

  localparam int SLOTS = SCHED_DEPTH_DEF;
  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_WORDS = 1000;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic        op;
    logic [11:0] temp;
    logic [9:0]  hum;
    logic [11:0] gas;
    logic [31:0] now_ms;
    logic [16:0] day;
    logic [3:0]  slot;
    logic [15:0] offset;
    logic [11:0] lo;
    logic [11:0] hi;
  } word_t;

  typedef struct packed {
    logic  h1;
    logic  h2;
    logic  vent;
    logic  mist;
    zone_t zone;
  } pins_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_MODE;
  logic [16:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = 1'b0;
  logic signed [11:0] in_temperature_tenths = '0;
  logic [9:0]         in_humidity_tenths = '0;
  logic [11:0]        in_gas_reading = '0;
  logic [31:0]        in_time_ms = '0;
  logic [16:0]        in_day_number = '0;
  logic [3:0]         in_entry_index = '0;
  logic [15:0]        in_entry_day_offset = '0;
  logic signed [11:0] in_entry_min_tenths = '0;
  logic signed [11:0] in_entry_max_tenths = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_heater_one_level;
  logic               out_heater_two_level;
  logic               out_vent_level;
  logic               out_mist_level;
  logic [1:0]         out_zone_seen;

  // Shadow copy of the registers and the relay state.
  logic [2:0]  mode_sel = MODE_AUTO;
  logic [11:0] auto_lo = 12'd280;
  logic [11:0] auto_hi = 12'd320;
  logic [11:0] hold_s = 12'd10;
  logic [9:0]  hum_set = 10'd700;
  logic [11:0] gas_set = 12'd2000;
  logic [16:0] start_day = '0;
  logic [4:0]  slot_count = '0;
  logic        h1_pin = 1'b0;
  logic        h2_pin = 1'b0;
  logic        vent_pin = 1'b0;
  logic        mist_pin = 1'b0;
  zone_t       auto_zone = ZONE_NONE;
  zone_t       sched_zone = ZONE_NONE;
  zone_t       sched_applied = ZONE_NONE;
  logic [31:0] auto_since = '0;
  logic [31:0] sched_since = '0;
  logic [15:0] slot_offset [SLOTS];
  logic [11:0] slot_lo [SLOTS];
  logic [11:0] slot_hi [SLOTS];

  pins_t       pin_queue [$];
  pins_t       want_pins;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  bit          send_calm = 1'b0;
  bit          sink_calm = 1'b0;
  logic [31:0] clock_ms = '0;

  climate_relay_controller_core u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_temperature_tenths (in_temperature_tenths),
    .in_humidity_tenths    (in_humidity_tenths),
    .in_gas_reading        (in_gas_reading),
    .in_time_ms            (in_time_ms),
    .in_day_number         (in_day_number),
    .in_entry_index        (in_entry_index),
    .in_entry_day_offset   (in_entry_day_offset),
    .in_entry_min_tenths   (in_entry_min_tenths),
    .in_entry_max_tenths   (in_entry_max_tenths),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_heater_one_level  (out_heater_one_level),
    .out_heater_two_level  (out_heater_two_level),
    .out_vent_level        (out_vent_level),
    .out_mist_level        (out_mist_level),
    .out_zone_seen         (out_zone_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic int pause_len(bit calm);
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic zone_t zone_of(logic [11:0] t, logic [11:0] lo, logic [11:0] hi);
    if ($signed(t) <= $signed(lo)) begin
      return ZONE_COLD;
    end
    if ($signed(t) < $signed(hi)) begin
      return ZONE_INSIDE;
    end
    return ZONE_HOT;
  endfunction

  function automatic bit zone_held(logic [31:0] now_ms, logic [31:0] since);
    logic [31:0] span;
    logic [31:0] need;
    span = now_ms - since;
    need = 32'(hold_s) * 32'(MS_PER_SECOND);
    return span >= need;
  endfunction

  task automatic set_heaters(input zone_t z);
    case (z)
      ZONE_COLD: begin
        h1_pin = 1'b0;
        h2_pin = 1'b0;
      end
      ZONE_INSIDE: begin
        h1_pin = 1'b1;
        h2_pin = 1'b0;
      end
      default: begin
        h1_pin = 1'b1;
        h2_pin = 1'b1;
      end
    endcase
  endtask

  task automatic predict_pins(input word_t w, output pins_t r);
    zone_t       z;
    logic [2:0]  m;
    logic [11:0] lo;
    logic [11:0] hi;
    int          days;
    int          n;
    bit          walking;
    bit          vent;
    bit          mist;
    z = ZONE_NONE;
    if (w.op) begin
      slot_offset[w.slot] = w.offset;
      slot_lo[w.slot] = w.lo;
      slot_hi[w.slot] = w.hi;
    end else begin
      m = (mode_sel >= MODE_COUNT) ? mode_sel - MODE_COUNT : mode_sel;
      case (m)
        MODE_AUTO: begin
          z = zone_of(w.temp, auto_lo, auto_hi);
          if (z != auto_zone) begin
            auto_zone = z;
            auto_since = w.now_ms;
          end
          if (zone_held(w.now_ms, auto_since)) begin
            set_heaters(z);
          end
        end
        MODE_OFF: begin
          h1_pin = 1'b1;
          h2_pin = 1'b1;
        end
        MODE_ON: begin
          h1_pin = 1'b0;
          h2_pin = 1'b0;
        end
        MODE_HALF: begin
          h1_pin = 1'b0;
          h2_pin = 1'b1;
        end
        default: begin
          days = 0;
          lo = DEF_MIN_TENTHS;
          hi = DEF_MAX_TENTHS;
          n = (int'(slot_count) < SLOTS) ? int'(slot_count) : SLOTS;
          if (start_day != '0) begin
            days = int'(w.day) - int'(start_day);
            if (days < 0) begin
              days = 0;
            end
            if (days > DAYS_MAX) begin
              days = DAYS_MAX;
            end
          end
          walking = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (walking && int'(slot_offset[i]) <= days) begin
              lo = slot_lo[i];
              hi = slot_hi[i];
            end else begin
              walking = 1'b0;
            end
          end
          z = zone_of(w.temp, lo, hi);
          if (z != sched_zone) begin
            sched_zone = z;
            sched_since = w.now_ms;
          end
          if (zone_held(w.now_ms, sched_since) && sched_applied != z) begin
            sched_applied = z;
            set_heaters(z);
          end
        end
      endcase
      vent = int'(w.hum) > int'(hum_set) + HUM_BAND_TENTHS;
      mist = !vent && (int'(w.hum) < int'(hum_set) - HUM_BAND_TENTHS);
      if (w.gas > gas_set) begin
        vent = 1'b1;
      end
      vent_pin = !vent;
      mist_pin = !mist;
    end
    r.h1 = h1_pin;
    r.h2 = h2_pin;
    r.vent = vent_pin;
    r.mist = mist_pin;
    r.zone = z;
  endtask

  function automatic word_t tick(int temp, int hum, int gas, logic [31:0] t_ms, int day);
    word_t w;
    w.op = 1'b0;
    w.temp = 12'(temp);
    w.hum = 10'(hum);
    w.gas = 12'(gas);
    w.now_ms = t_ms;
    w.day = 17'(day);
    w.slot = 4'($urandom);
    w.offset = 16'($urandom);
    w.lo = 12'($urandom);
    w.hi = 12'($urandom);
    return w;
  endfunction

  function automatic word_t slot_word(int idx, int off, int lo, int hi);
    word_t w;
    w.op = 1'b1;
    w.temp = 12'($urandom);
    w.hum = 10'($urandom);
    w.gas = 12'($urandom);
    w.now_ms = $urandom;
    w.day = 17'($urandom);
    w.slot = 4'(idx);
    w.offset = 16'(off);
    w.lo = 12'(lo);
    w.hi = 12'(hi);
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("cycle %0d, result %0d: %s", cycle_count, results_seen, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pin_queue.size() == 0) begin
        report_mismatch("result word arrived with nothing expected");
      end else begin
        want_pins = pin_queue.pop_front();
        check_field("heater one level", {1'b0, out_heater_one_level}, {1'b0, want_pins.h1});
        check_field("heater two level", {1'b0, out_heater_two_level}, {1'b0, want_pins.h2});
        check_field("vent level", {1'b0, out_vent_level}, {1'b0, want_pins.vent});
        check_field("mist level", {1'b0, out_mist_level}, {1'b0, want_pins.mist});
        check_field("zone", out_zone_seen, want_pins.zone);
      end
    end
  end

  initial begin : sink
    int stall;
    forever begin
      stall = pause_len(sink_calm);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(40, 400)) @(negedge clk);
      send_calm = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_word(input word_t w);
    int    gap;
    pins_t want;
    gap = pause_len(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op <= w.op;
    in_temperature_tenths <= w.temp;
    in_humidity_tenths <= w.hum;
    in_gas_reading <= w.gas;
    in_time_ms <= w.now_ms;
    in_day_number <= w.day;
    in_entry_index <= w.slot;
    in_entry_day_offset <= w.offset;
    in_entry_min_tenths <= w.lo;
    in_entry_max_tenths <= w.hi;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_pins(w, want);
    pin_queue.push_back(want);
    words_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:      mode_sel = val[2:0];
      REG_AUTO_MIN:  auto_lo = val[11:0];
      REG_AUTO_MAX:  auto_hi = val[11:0];
      REG_DELAY:     hold_s = val[11:0];
      REG_HUM_LIMIT: hum_set = val[9:0];
      REG_GAS_LIMIT: gas_set = val[11:0];
      REG_START_DAY: start_day = val;
      default:       slot_count = val[4:0];
    endcase
  endtask

  task automatic pick_band(output int lo, output int hi);
    lo = int'($urandom_range(0, 1650)) - 400;
    if ($urandom_range(0, 7) == 0) begin
      hi = lo - int'($urandom_range(0, 100));
    end else begin
      hi = lo + int'($urandom_range(1, 200));
    end
    if (hi > 1250) begin
      hi = 1250;
    end
    if (hi < -400) begin
      hi = -400;
    end
  endtask

  task automatic test_forced_modes();
    settle();
    write_reg(REG_MODE, 17'(MODE_OFF));
    send_word(tick(-400, 700 + HUM_BAND_TENTHS, 2000, 32'd0, 0));
    settle();
    write_reg(REG_MODE, 17'(MODE_ON));
    send_word(tick(1250, 700 + HUM_BAND_TENTHS + 1, 2000, 32'd10, 1));
    settle();
    write_reg(REG_MODE, 17'(MODE_HALF));
    send_word(tick(0, 700 - HUM_BAND_TENTHS, 0, 32'd20, 2));
    settle();
    write_reg(REG_MODE, 17'(MODE_COUNT + MODE_AUTO));
    send_word(tick(1250, 700 - HUM_BAND_TENTHS - 1, 2000, 32'd0, 3));
    settle();
    write_reg(REG_MODE, 17'(MODE_COUNT + MODE_OFF));
    send_word(tick(500, 0, 2001, 32'd40, 4));
    settle();
    write_reg(REG_MODE, 17'(MODE_COUNT + MODE_ON));
    send_word(tick(500, 1000, 4095, 32'd50, 5));
  endtask

  task automatic test_auto_hold();
    settle();
    write_reg(REG_MODE, 17'(MODE_AUTO));
    write_reg(REG_AUTO_MIN, 17'(12'(280)));
    write_reg(REG_AUTO_MAX, 17'(12'(320)));
    write_reg(REG_DELAY, 17'd1);
    send_word(tick(280, 700, 0, 32'd5000, 0));
    send_word(tick(200, 650, 0, 32'd5999, 0));
    send_word(tick(200, 700, 0, 32'd6000, 0));
    send_word(tick(320, 760, 0, 32'd6500, 0));
    send_word(tick(1250, 700, 0, 32'd7500, 0));
    send_word(tick(300, 700, 0, 32'hFFFF_FF00, 0));
    send_word(tick(319, 700, 0, 32'h0000_0300, 0));
    settle();
    // Crossed thresholds leave no temperature inside the band.
    write_reg(REG_AUTO_MIN, 17'(12'(1250)));
    write_reg(REG_AUTO_MAX, 17'(12'(-400)));
    write_reg(REG_DELAY, 17'd0);
    send_word(tick(1250, 700, 0, 32'd8000, 0));
    send_word(tick(-400, 700, 0, 32'd8001, 0));
  endtask

  task automatic test_schedule_walk();
    settle();
    send_word(slot_word(0, 0, -400, 1250));
    send_word(slot_word(1, 10, 100, 200));
    send_word(slot_word(2, 20, 250, 250));
    send_word(slot_word(3, 65535, 0, 0));
    settle();
    write_reg(REG_START_DAY, 17'd100);
    write_reg(REG_SCHED_CNT, 17'd4);
    write_reg(REG_MODE, 17'(MODE_SCHED));
    send_word(tick(0, 700, 0, 32'd100, 50));
    send_word(tick(0, 700, 0, 32'd200, 100));
    send_word(tick(150, 700, 0, 32'd300, 115));
    send_word(tick(200, 700, 0, 32'd400, 115));
    send_word(tick(0, 700, 0, 32'd500, 131071));
    send_word(tick(250, 700, 0, 32'd600, 120));
    send_word(tick(251, 700, 0, 32'd700, 120));
    settle();
    write_reg(REG_START_DAY, 17'd0);
    write_reg(REG_SCHED_CNT, 17'd0);
    send_word(tick(300, 700, 0, 32'd800, 500));
  endtask

  task automatic test_random_traffic();
    int first;
    int lo;
    int hi;
    int temp_walk;
    int t;
    int h;
    int g;
    int d;
    logic [2:0] m;
    first = words_sent;
    settle();
    // Every slot is written before any walk can reach it.
    for (int i = 0; i < SLOTS; i++) begin
      pick_band(lo, hi);
      send_word(slot_word(i, i * 50 + int'($urandom_range(0, 49)), lo, hi));
    end
    temp_walk = 300;
    while (words_sent - first < RANDOM_WORDS) begin
      settle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: m = MODE_SCHED;
        4, 5, 6:    m = MODE_AUTO;
        default:    m = 3'($urandom_range(0, 7));
      endcase
      write_reg(REG_MODE, 17'(m));
      pick_band(lo, hi);
      if ($urandom_range(0, 9) == 0) begin
        lo = int'($urandom_range(0, 4095)) - 2048;
        hi = int'($urandom_range(0, 4095)) - 2048;
      end
      write_reg(REG_AUTO_MIN, 17'(12'(lo)));
      write_reg(REG_AUTO_MAX, 17'(12'(hi)));
      case ($urandom_range(0, 9))
        0:       write_reg(REG_DELAY, 17'd4095);
        1:       write_reg(REG_DELAY, 17'd3600);
        default: write_reg(REG_DELAY, 17'($urandom_range(0, 3)));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(REG_HUM_LIMIT, 17'd0);
        1:       write_reg(REG_HUM_LIMIT, 17'd1023);
        2:       write_reg(REG_HUM_LIMIT, 17'd1000);
        default: write_reg(REG_HUM_LIMIT, 17'($urandom_range(0, 1000)));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(REG_GAS_LIMIT, 17'd0);
        1:       write_reg(REG_GAS_LIMIT, 17'd4095);
        default: write_reg(REG_GAS_LIMIT, 17'($urandom_range(0, 4095)));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(REG_START_DAY, 17'd0);
        1:       write_reg(REG_START_DAY, 17'd131071);
        default: write_reg(REG_START_DAY, 17'($urandom_range(1, 120000)));
      endcase
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_SCHED_CNT, 17'($urandom_range(17, 31)));
      end else begin
        write_reg(REG_SCHED_CNT, 17'($urandom_range(0, 16)));
      end
      temp_walk = int'($signed(auto_lo)) + int'($urandom_range(0, 40)) - 20;
      repeat ($urandom_range(10, 60)) begin
        if ($urandom_range(0, 9) == 0) begin
          pick_band(lo, hi);
          t = int'($urandom_range(0, 15));
          if ($urandom_range(0, 7) == 0) begin
            send_word(slot_word(t, int'($urandom_range(0, 65535)), lo, hi));
          end else begin
            send_word(slot_word(t, t * 50 + int'($urandom_range(0, 49)), lo, hi));
          end
        end else begin
          case ($urandom_range(0, 29))
            0:       clock_ms = $urandom;
            1:       clock_ms += $urandom_range(0, 4000000);
            default: clock_ms += $urandom_range(0, 1500);
          endcase
          temp_walk += int'($urandom_range(0, 30)) - 15;
          if ($urandom_range(0, 15) == 0) begin
            temp_walk = int'($urandom_range(0, 1650)) - 400;
          end
          if (temp_walk > 1250) begin
            temp_walk = 1250;
          end
          if (temp_walk < -400) begin
            temp_walk = -400;
          end
          t = temp_walk;
          if ($urandom_range(0, 11) == 0) begin
            t = int'($urandom_range(0, 4095)) - 2048;
          end
          if ($urandom_range(0, 4) == 0) begin
            h = int'($urandom_range(0, 1023));
          end else begin
            h = int'(hum_set) + int'($urandom_range(0, 80)) - 40;
            h = (h < 0) ? 0 : ((h > 1023) ? 1023 : h);
          end
          if ($urandom_range(0, 1) == 0) begin
            g = int'($urandom_range(0, 4095));
          end else begin
            g = int'(gas_set) + int'($urandom_range(0, 4)) - 2;
            g = (g < 0) ? 0 : ((g > 4095) ? 4095 : g);
          end
          if ($urandom_range(0, 7) == 0) begin
            d = int'($urandom_range(0, 131071));
          end else begin
            d = int'(start_day) + int'($urandom_range(0, 950)) - 50;
            d = (d < 0) ? 0 : d;
          end
          send_word(tick(t, h, g, clock_ms, d));
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_forced_modes();
    test_auto_hold();
    test_schedule_walk();
    test_random_traffic();
    settle();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && pin_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
